FILE: design/cross_stencil_star_counter_defines.svh
// Assertion macros shared by the checker of the star counter.
// Holds no logic; files that check behavior include it by name.
`ifndef CROSS_STENCIL_STAR_COUNTER_DEFINES_SVH
`define CROSS_STENCIL_STAR_COUNTER_DEFINES_SVH

// Same-cycle implication, quiet while reset is high.
`define CSSC_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, quiet while reset is high.
`define CSSC_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that is also checked around reset.
`define CSSC_ASSERT_NXT_ALL(lbl, clk, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/cssc_pkg.sv
// Shared types and constants of the cross stencil star counter.
// No dependencies; used by the top level, the checker and the testbench.
`timescale 1ns / 1ps
`default_nettype none

package cssc_pkg;

  // Configuration port.
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 11;
  localparam int THRESH_W    = 8;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_FRAME_WIDTH    = 2'd0,
    REG_FRAME_HEIGHT   = 2'd1,
    REG_MEAN_THRESHOLD = 2'd2
  } cfg_reg_t;

  // Register reset values.
  localparam logic [CFG_DATA_W-1:0] FRAME_WIDTH_RST  = 11'd8;
  localparam logic [CFG_DATA_W-1:0] FRAME_HEIGHT_RST = 11'd6;
  localparam logic [THRESH_W-1:0]   THRESH_RST       = 8'd6;

  // Frame geometry limits.
  localparam int SIZE_MIN = 3;
  localparam int ROW_W    = 10;
  localparam int ROW_MAX  = 1024;

  // Result width and the width of five times the threshold.
  localparam int COUNT_W = 20;
  localparam int LIMIT_W = THRESH_W + 3;

  typedef logic [COUNT_W-1:0] count_t;

endpackage

`default_nettype wire

FILE: design/cssc_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// Read during a write to the same address returns the old contents.
`timescale 1ns / 1ps
`default_nettype none

module cssc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Storage array with a registered read.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

FILE: design/cross_stencil_star_counter.sv
// Cross stencil star counter. Pixels arrive in raster order, one per clock while pixel_ready
// is high; for every interior pixel the sum of the pixel and its four cross neighbors is
// compared against five times mean_threshold, and after the last pixel of a frame one
// transfer on the star channel carries the frame's star count. A pixel's result, if any,
// passes through the s1 register into a two-entry output queue, so pixel_ready only drops
// on a frame's last pixel while two counts are still waiting to be taken. The two
// previous rows live in two MAX_WIDTH-deep line-buffer RAMs whose single read port per buffer
// sets the one-pixel-per-clock rate; they need no clearing pass after reset. Frame size and
// threshold may only be changed between frames. Depends on cssc_pkg and cssc_ram.
`timescale 1ns / 1ps
`default_nettype none

module cross_stencil_star_counter #(
  parameter int MAX_WIDTH  = 1024,
  parameter int PIXEL_BITS = 8
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_we,
  input  wire logic [cssc_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  wire logic [cssc_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  wire logic                               pixel_valid,
  output logic                                    pixel_ready,
  input  wire logic [PIXEL_BITS-1:0]              pixel,
  output logic                                    star_valid,
  input  wire logic                               star_ready,
  output logic      [cssc_pkg::COUNT_W-1:0]       star_count
);

  localparam int AW    = $clog2(MAX_WIDTH);
  localparam int SW    = (AW + 1 > cssc_pkg::CFG_DATA_W) ? AW + 1 : cssc_pkg::CFG_DATA_W;
  localparam int SUM_W = (PIXEL_BITS + 3 > cssc_pkg::LIMIT_W) ? PIXEL_BITS + 3
                                                                : cssc_pkg::LIMIT_W;
  localparam int HW    = cssc_pkg::CFG_DATA_W;

  // Configuration registers.
  logic [cssc_pkg::CFG_DATA_W-1:0] frame_width;
  logic [cssc_pkg::CFG_DATA_W-1:0] frame_height;
  logic [cssc_pkg::THRESH_W-1:0]   mean_threshold;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width    <= cssc_pkg::FRAME_WIDTH_RST;
      frame_height   <= cssc_pkg::FRAME_HEIGHT_RST;
      mean_threshold <= cssc_pkg::THRESH_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        cssc_pkg::REG_FRAME_WIDTH:    frame_width    <= cfg_data;
        cssc_pkg::REG_FRAME_HEIGHT:   frame_height   <= cfg_data;
        cssc_pkg::REG_MEAN_THRESHOLD: mean_threshold <= cfg_data[cssc_pkg::THRESH_W-1:0];
        default: ;
      endcase
    end
  end

  // Frame size saturated to the supported range.
  logic [SW-1:0] width_ext;
  logic [SW-1:0] width_eff;
  logic [HW-1:0] height_eff;

  assign width_ext = SW'(frame_width);

  always_comb begin
    if (width_ext < SW'(cssc_pkg::SIZE_MIN)) begin
      width_eff = SW'(cssc_pkg::SIZE_MIN);
    end else if (width_ext > SW'(MAX_WIDTH)) begin
      width_eff = SW'(MAX_WIDTH);
    end else begin
      width_eff = width_ext;
    end
    if (frame_height < HW'(cssc_pkg::SIZE_MIN)) begin
      height_eff = HW'(cssc_pkg::SIZE_MIN);
    end else if (frame_height > HW'(cssc_pkg::ROW_MAX)) begin
      height_eff = HW'(cssc_pkg::ROW_MAX);
    end else begin
      height_eff = frame_height;
    end
  end

  // Raster position of the next pixel.
  logic [AW-1:0]              col;
  logic [cssc_pkg::ROW_W-1:0] row;
  logic                       col_last;
  logic                       row_last;
  logic                       frame_end;
  logic                       accept;

  assign col_last  = (SW'(col) + SW'(1)) >= width_eff;
  assign row_last  = (HW'(row) + HW'(1)) >= height_eff;
  assign frame_end = col_last && row_last;

  // Pipeline register between the line-buffer read and the stencil evaluation.
  logic                  s1_valid;
  logic                  s1_center;
  logic                  s1_last;
  logic [AW-1:0]         s1_addr;
  logic [PIXEL_BITS-1:0] s1_pixel;

  // Output queue state.
  logic [1:0]            q_count;
  cssc_pkg::count_t      q_head;
  cssc_pkg::count_t      q_tail;
  logic                  push;
  logic                  pop;
  cssc_pkg::count_t      push_data;

  // A frame's last pixel needs a free queue slot by the time its count is ready.
  assign pixel_ready = !frame_end || ((3'(q_count) + 3'(push)) < 3'd2);
  assign accept      = pixel_valid && pixel_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (accept) begin
      if (col_last) begin
        col <= '0;
        row <= row_last ? '0 : row + cssc_pkg::ROW_W'(1);
      end else begin
        col <= col + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_center <= (row >= cssc_pkg::ROW_W'(2)) && (col >= AW'(2));
      s1_last   <= frame_end;
      s1_addr   <= col;
      s1_pixel  <= pixel;
    end
  end

  // Line buffers: the row above is rewritten with the new pixel as it is read,
  // and the row two above takes the old row-above value in the following cycle.
  logic [PIXEL_BITS-1:0] above;
  logic [PIXEL_BITS-1:0] above2;

  cssc_ram #(
    .WIDTH (PIXEL_BITS),
    .DEPTH (MAX_WIDTH)
  ) u_row_above (
    .clk     (clk),
    .wr_en   (accept),
    .wr_addr (col),
    .wr_data (pixel),
    .rd_en   (accept),
    .rd_addr (col),
    .rd_data (above)
  );

  cssc_ram #(
    .WIDTH (PIXEL_BITS),
    .DEPTH (MAX_WIDTH)
  ) u_two_rows_above (
    .clk     (clk),
    .wr_en   (s1_valid),
    .wr_addr (s1_addr),
    .wr_data (above),
    .rd_en   (accept),
    .rd_addr (col),
    .rd_data (above2)
  );

  // Stencil window: two older middle-row pixels plus the upper and lower holds.
  logic [PIXEL_BITS-1:0] win_a;
  logic [PIXEL_BITS-1:0] win_b;
  logic [PIXEL_BITS-1:0] upper_hold;
  logic [PIXEL_BITS-1:0] lower_hold;
  logic [SUM_W-1:0]      cross_sum;
  logic [SUM_W-1:0]      star_limit;
  logic                  star_hit;
  cssc_pkg::count_t      tally;
  cssc_pkg::count_t      tally_next;

  assign cross_sum  = SUM_W'(win_a) + SUM_W'(win_b) + SUM_W'(above)
                    + SUM_W'(upper_hold) + SUM_W'(lower_hold);
  assign star_limit = SUM_W'({mean_threshold, 2'b00}) + SUM_W'(mean_threshold);
  assign star_hit   = s1_center && (cross_sum > star_limit);
  assign tally_next = tally + cssc_pkg::COUNT_W'(star_hit);

  always_ff @(posedge clk) begin
    if (rst) begin
      win_a      <= '0;
      win_b      <= '0;
      upper_hold <= '0;
      lower_hold <= '0;
      tally      <= '0;
    end else if (s1_valid) begin
      win_a      <= win_b;
      win_b      <= above;
      upper_hold <= above2;
      lower_hold <= s1_pixel;
      tally      <= s1_last ? '0 : tally_next;
    end
  end

  // Two-entry output queue of finished frame counts.
  assign push      = s1_valid && s1_last;
  assign push_data = tally_next;
  assign pop       = star_valid && star_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_count <= '0;
    end else begin
      q_count <= q_count + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push && pop) begin
      if (q_count == 2'd1) begin
        q_head <= push_data;
      end else begin
        q_head <= q_tail;
        q_tail <= push_data;
      end
    end else if (pop) begin
      q_head <= q_tail;
    end else if (push) begin
      if (q_count == 2'd0) begin
        q_head <= push_data;
      end else begin
        q_tail <= push_data;
      end
    end
  end

  assign star_valid = (q_count != 2'd0);
  assign star_count = q_head;

endmodule

`default_nettype wire

FILE: design/cssc_checker.sv
// Port-level checker for the cross stencil star counter, bound to the top level.
// Depends on cssc_pkg and the assertion macros in cross_stencil_star_counter_defines.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "cross_stencil_star_counter_defines.svh"

module cssc_checker (
  input wire logic             clk,
  input wire logic             rst,
  input wire logic             pixel_valid,
  input wire logic             pixel_ready,
  input wire logic             star_valid,
  input wire logic             star_ready,
  input wire cssc_pkg::count_t star_count
);

  // A held count stays offered and unchanged until its transfer.
  `CSSC_ASSERT_NXT(a_star_hold, clk, rst, star_valid && !star_ready, star_valid && $stable(star_count), "star count dropped or changed while stalled")

  // Reset leaves the output queue empty and the pixel side open.
  `CSSC_ASSERT_NXT_ALL(a_reset_state, clk, rst, !star_valid && pixel_ready, "reset did not empty the queue or open the input")

  // A new count appears only after a pixel transfer, through the pipeline register and the output queue.
  `CSSC_ASSERT_IMP(a_count_source, clk, rst, $rose(star_valid), $past(pixel_valid && pixel_ready, 2), "star count without a preceding pixel transfer")

endmodule

bind cross_stencil_star_counter cssc_checker u_cssc_checker (.*);

`default_nettype wire

FILE: tb/cross_stencil_star_counter_tb.sv
// Self-checking testbench for the cross stencil star counter.
// Streams raster frames, predicts each frame's star count and checks every result transfer.
// Depends on cssc_pkg and the cross_stencil_star_counter RTL.
`timescale 1ns / 1ps

module cross_stencil_star_counter_tb;

  localparam int PIX_W          = 8;
  localparam int LINE_DEPTH     = 1024;
  localparam int DRAIN_CYCLES   = 6;
  localparam int END_CYCLES     = 16;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int PHASE_ITEMS    = 360;

  // Register index outside the mapped list; the block must ignore writes to it.
  localparam logic [cssc_pkg::CFG_INDEX_W-1:0] REG_UNMAPPED = 2'd3;

  typedef enum int {
    PIX_UNIFORM,
    PIX_NEAR_THRESHOLD,
    PIX_SPARSE
  } pixel_style_e;

  logic                             clk;
  logic                             rst         = 1'b1;
  logic                             cfg_we      = 1'b0;
  logic [cssc_pkg::CFG_INDEX_W-1:0] cfg_index   = '0;
  logic [cssc_pkg::CFG_DATA_W-1:0]  cfg_data    = '0;
  logic                             pixel_valid = 1'b0;
  logic                             pixel_ready;
  logic [PIX_W-1:0]                 pixel       = '0;
  logic                             star_valid;
  logic                             star_ready  = 1'b0;
  cssc_pkg::count_t                 star_count;

  cross_stencil_star_counter dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .pixel_valid (pixel_valid),
    .pixel_ready (pixel_ready),
    .pixel       (pixel),
    .star_valid  (star_valid),
    .star_ready  (star_ready),
    .star_count  (star_count)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Pacing of both channels, changed per test phase.
  int unsigned send_gap_pct = 0;
  int unsigned stall_pct    = 0;
  int unsigned pixels_sent  = 0;
  int          error_count  = 0;
  int          quiet_cycles = 0;

  // Predictor state: configuration copy, line buffers, window and counters.
  logic [cssc_pkg::CFG_DATA_W-1:0] width_reg  = cssc_pkg::FRAME_WIDTH_RST;
  logic [cssc_pkg::CFG_DATA_W-1:0] height_reg = cssc_pkg::FRAME_HEIGHT_RST;
  logic [cssc_pkg::THRESH_W-1:0]   thresh_reg = cssc_pkg::THRESH_RST;
  logic [PIX_W-1:0]      line_above     [LINE_DEPTH];
  logic [PIX_W-1:0]      line_two_above [LINE_DEPTH];
  logic [PIX_W-1:0]      mid_window     [3];
  logic [PIX_W-1:0]      upper_hold;
  logic [PIX_W-1:0]      lower_hold;
  int unsigned           col_pos;
  int unsigned           row_pos;
  logic [20:0]           star_tally;
  cssc_pkg::count_t      pending_counts[$];

  // Frame dimensions saturate into the supported range.
  function automatic int unsigned clamp_dim(input logic [cssc_pkg::CFG_DATA_W-1:0] v,
                                            input int unsigned hi);
    if (v < cssc_pkg::SIZE_MIN) return cssc_pkg::SIZE_MIN;
    if (v > hi) return hi;
    return v;
  endfunction

  // Advances the stencil by one pixel; a finished frame queues its star count.
  task automatic stencil_step(input logic [PIX_W-1:0] px);
    int unsigned     w;
    int unsigned     h;
    int unsigned     cross_sum;
    logic [PIX_W-1:0] above;
    logic [PIX_W-1:0] above2;
    w      = clamp_dim(width_reg, LINE_DEPTH);
    h      = clamp_dim(height_reg, cssc_pkg::ROW_MAX);
    above  = line_above[col_pos];
    above2 = line_two_above[col_pos];
    mid_window[0] = mid_window[1];
    mid_window[1] = mid_window[2];
    mid_window[2] = above;
    // The cross is centered one row up and one column left of the new pixel.
    if (row_pos >= 2 && col_pos >= 2) begin
      cross_sum = mid_window[0] + mid_window[1] + mid_window[2] + upper_hold + lower_hold;
      if (cross_sum > 5 * thresh_reg) star_tally = star_tally + 1'b1;
    end
    upper_hold = above2;
    lower_hold = px;
    line_two_above[col_pos] = above;
    line_above[col_pos]     = px;
    if (col_pos + 1 >= w) begin
      col_pos = 0;
      if (row_pos + 1 >= h) begin
        pending_counts.push_back(star_tally[cssc_pkg::COUNT_W-1:0]);
        star_tally = '0;
        row_pos    = 0;
      end else begin
        row_pos = row_pos + 1;
      end
    end else begin
      col_pos = col_pos + 1;
    end
  endtask

  function automatic logic [PIX_W-1:0] draw_pixel(input pixel_style_e style);
    int unsigned lo;
    int unsigned hi;
    case (style)
      PIX_UNIFORM: begin
        return PIX_W'($urandom_range(255));
      end
      PIX_NEAR_THRESHOLD: begin
        // Keeps cross sums close to five times the threshold on both sides.
        lo = (thresh_reg > 2) ? thresh_reg - 2 : 0;
        hi = (thresh_reg < 253) ? thresh_reg + 2 : 255;
        return PIX_W'($urandom_range(hi, lo));
      end
      default: begin
        return ($urandom_range(7) == 0) ? PIX_W'($urandom_range(255, 128))
                                        : PIX_W'($urandom_range(15));
      end
    endcase
  endfunction

  task automatic set_pacing(input int unsigned gap, input int unsigned stall);
    send_gap_pct = gap;
    stall_pct    = stall;
  endtask

  // One pixel transfer; valid stays high on return so pixels can stream back to back.
  task automatic send_pixel(input logic [PIX_W-1:0] value);
    while ($urandom_range(99) < send_gap_pct) begin
      pixel_valid <= 1'b0;
      @(posedge clk);
    end
    pixel_valid <= 1'b1;
    pixel       <= value;
    @(posedge clk);
    while (!pixel_ready) @(posedge clk);
    stencil_step(value);
    pixels_sent++;
  endtask

  task automatic send_frame(input pixel_style_e style);
    int unsigned n;
    n = clamp_dim(width_reg, LINE_DEPTH) * clamp_dim(height_reg, cssc_pkg::ROW_MAX);
    repeat (n) send_pixel(draw_pixel(style));
  endtask

  // Stops the pixel stream and waits until every predicted count has been taken.
  task automatic hold_until_drained();
    pixel_valid <= 1'b0;
    while (pending_counts.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_reg(input logic [cssc_pkg::CFG_INDEX_W-1:0] idx,
                         input logic [cssc_pkg::CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    case (idx)
      cssc_pkg::REG_FRAME_WIDTH:    width_reg  = data;
      cssc_pkg::REG_FRAME_HEIGHT:   height_reg = data;
      cssc_pkg::REG_MEAN_THRESHOLD: thresh_reg = data[cssc_pkg::THRESH_W-1:0];
      default: ;
    endcase
  endtask

  task automatic end_cfg();
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Reconfigures only between frames, once the block has gone idle.
  task automatic configure_frame(input logic [cssc_pkg::CFG_DATA_W-1:0] w,
                                 input logic [cssc_pkg::CFG_DATA_W-1:0] h,
                                 input logic [cssc_pkg::CFG_DATA_W-1:0] thr);
    hold_until_drained();
    set_reg(cssc_pkg::REG_FRAME_WIDTH, w);
    set_reg(cssc_pkg::REG_FRAME_HEIGHT, h);
    set_reg(cssc_pkg::REG_MEAN_THRESHOLD, thr);
    end_cfg();
  endtask

  task automatic random_setup();
    logic [cssc_pkg::CFG_DATA_W-1:0] w;
    logic [cssc_pkg::CFG_DATA_W-1:0] h;
    case ($urandom_range(9))
      0: begin
        // Below the minimum; both sizes saturate to three.
        w = cssc_pkg::CFG_DATA_W'($urandom_range(2));
        h = cssc_pkg::CFG_DATA_W'($urandom_range(2));
      end
      1, 2: begin
        w = cssc_pkg::CFG_DATA_W'($urandom_range(48, 3));
        h = cssc_pkg::CFG_DATA_W'($urandom_range(16, 3));
      end
      default: begin
        w = cssc_pkg::CFG_DATA_W'($urandom_range(10, 3));
        h = cssc_pkg::CFG_DATA_W'($urandom_range(6, 3));
      end
    endcase
    configure_frame(w, h, cssc_pkg::CFG_DATA_W'($urandom()));
  endtask

  // One frame at the reset configuration, without any register write.
  task automatic test_reset_defaults();
    set_pacing(0, 0);
    send_frame(PIX_NEAR_THRESHOLD);
  endtask

  // Threshold boundary: equal sum, maximum threshold and the smallest sum above it.
  task automatic test_threshold_edges();
    logic [PIX_W-1:0] frame_px [9];
    set_pacing(0, 0);
    // Cross sums to exactly five times six; bright corners lie outside the cross.
    configure_frame(11'd3, 11'd3, 11'd6);
    frame_px = '{8'd255, 8'd6, 8'd255, 8'd6, 8'd6, 8'd6, 8'd255, 8'd6, 8'd255};
    foreach (frame_px[i]) send_pixel(frame_px[i]);
    // Upper data bits are dropped, so the threshold becomes 255 and full white fails.
    configure_frame(11'd3, 11'd3, 11'h7FF);
    frame_px = '{default: 8'd255};
    foreach (frame_px[i]) send_pixel(frame_px[i]);
    // Zero threshold: a single lit center pixel is a star.
    configure_frame(11'd3, 11'd3, 11'd0);
    frame_px = '{8'd0, 8'd0, 8'd0, 8'd0, 8'd1, 8'd0, 8'd0, 8'd0, 8'd0};
    foreach (frame_px[i]) send_pixel(frame_px[i]);
  endtask

  // A write to the unmapped index must leave size and threshold alone.
  task automatic test_unmapped_register();
    set_pacing(0, 0);
    configure_frame(11'd4, 11'd3, 11'd40);
    hold_until_drained();
    set_reg(REG_UNMAPPED, 11'h7FF);
    end_cfg();
    send_frame(PIX_NEAR_THRESHOLD);
    send_frame(PIX_UNIFORM);
  endtask

  // Sizes below the minimum saturate to three; a wider frame reaches deeper line addresses.
  task automatic test_size_limits();
    logic [cssc_pkg::CFG_DATA_W-1:0] widths  [4];
    logic [cssc_pkg::CFG_DATA_W-1:0] heights [4];
    set_pacing(0, 0);
    widths  = '{11'd0, 11'd2, 11'd1, 11'd64};
    heights = '{11'd2, 11'd0, 11'd1, 11'd3};
    foreach (widths[i]) begin
      configure_frame(widths[i], heights[i], cssc_pkg::CFG_DATA_W'($urandom_range(80)));
      send_frame(PIX_UNIFORM);
    end
  endtask

  // Random frames under each pacing mix; some frames stream back to back.
  task automatic test_random_frames();
    int unsigned gaps   [4];
    int unsigned stalls [4];
    int unsigned first;
    gaps   = '{0, 87, 0, 9};
    stalls = '{0, 0, 87, 9};
    for (int p = 0; p < 4; p++) begin
      set_pacing(gaps[p], stalls[p]);
      random_setup();
      first = pixels_sent;
      while (pixels_sent - first < PHASE_ITEMS) begin
        send_frame(pixel_style_e'($urandom_range(2)));
        if ($urandom_range(1) == 0) begin
          random_setup();
        end else if ($urandom_range(7) == 0) begin
          hold_until_drained();
        end
      end
    end
  endtask

  // Receiver back-pressure.
  always @(posedge clk) begin
    star_ready <= ($urandom_range(99) >= stall_pct);
  end

  // Each star count transfer is matched against the oldest predicted count.
  always @(posedge clk) begin
    cssc_pkg::count_t want;
    if (!rst && star_valid && star_ready) begin
      if (pending_counts.size() == 0) begin
        $error("star_count: expected no transfer, actual %0d", star_count);
        error_count++;
      end else begin
        want = pending_counts.pop_front();
        if (star_count !== want) begin
          $error("star_count mismatch: expected %0d, actual %0d", want, star_count);
          error_count++;
        end
      end
    end
  end

  // Watchdog on cycles without any transfer or register write.
  always @(posedge clk) begin
    if (rst || (pixel_valid && pixel_ready) || (star_valid && star_ready) || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("cross_stencil_star_counter_tb NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    foreach (line_above[i]) begin
      line_above[i]     = '0;
      line_two_above[i] = '0;
    end
    mid_window = '{default: '0};
    upper_hold = '0;
    lower_hold = '0;
    col_pos    = 0;
    row_pos    = 0;
    star_tally = '0;

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_threshold_edges();
    test_unmapped_register();
    test_size_limits();
    test_random_frames();

    hold_until_drained();
    repeat (END_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("cross_stencil_star_counter_tb OK");
    end else begin
      $display("cross_stencil_star_counter_tb NOT OK");
    end
    $finish;
  end

endmodule
